// ----- hw/rtl/rvd_pkg.sv -----
// Shared types, field layouts and operation codes for the RV32I instruction decoder.
package rvd_pkg;

    localparam int unsigned XLEN       = 32;
    localparam int unsigned REG_ADDR_W = 5;
    localparam int unsigned REG_COUNT  = 32;

    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

    localparam logic [3:0] ALU_ADD     = 4'd0;
    localparam logic [3:0] ALU_SUB     = 4'd1;
    localparam logic [3:0] ALU_SLL     = 4'd2;
    localparam logic [3:0] ALU_SLT     = 4'd3;
    localparam logic [3:0] ALU_SLTU    = 4'd4;
    localparam logic [3:0] ALU_XOR     = 4'd5;
    localparam logic [3:0] ALU_SRL     = 4'd6;
    localparam logic [3:0] ALU_SRA     = 4'd7;
    localparam logic [3:0] ALU_OR      = 4'd8;
    localparam logic [3:0] ALU_AND     = 4'd9;
    localparam logic [3:0] ALU_ECALL   = 4'd10;
    localparam logic [3:0] ALU_INVALID = 4'd11;

    localparam logic [1:0] WB_ALU  = 2'd0;
    localparam logic [1:0] WB_LOAD = 2'd1;
    localparam logic [1:0] WB_PC4  = 2'd2;

    localparam logic [1:0] CLASS_PLAIN  = 2'd0;
    localparam logic [1:0] CLASS_JUMP   = 2'd1;
    localparam logic [1:0] CLASS_BRANCH = 2'd2;
    localparam logic [1:0] CLASS_MEMORY = 2'd3;

    localparam logic [2:0] MEM_LB  = 3'd0;
    localparam logic [2:0] MEM_LH  = 3'd1;
    localparam logic [2:0] MEM_LW  = 3'd2;
    localparam logic [2:0] MEM_LBU = 3'd3;
    localparam logic [2:0] MEM_LHU = 3'd4;
    localparam logic [2:0] MEM_SB  = 3'd5;
    localparam logic [2:0] MEM_SH  = 3'd6;
    localparam logic [2:0] MEM_SW  = 3'd7;

    localparam logic [2:0] BR_EQ      = 3'd0;
    localparam logic [2:0] BR_NE      = 3'd1;
    localparam logic [2:0] BR_LT      = 3'd2;
    localparam logic [2:0] BR_GE      = 3'd3;
    localparam logic [2:0] BR_LTU     = 3'd4;
    localparam logic [2:0] BR_GEU     = 3'd5;
    localparam logic [2:0] BR_INVALID = 3'd6;

    typedef struct packed {
        logic                  cmd;
        logic [XLEN-1:0]       instruction;
        logic [XLEN-1:0]       fetch_pc;
        logic [REG_ADDR_W-1:0] write_index;
        logic [XLEN-1:0]       write_value;
    } item_t;

    typedef struct packed {
        logic [3:0]            alu_operation;
        logic [XLEN-1:0]       operand_a;
        logic [XLEN-1:0]       operand_b;
        logic                  operand_b_is_imm;
        logic [XLEN-1:0]       store_data;
        logic [REG_ADDR_W-1:0] dest_reg;
        logic [1:0]            writeback_source;
        logic                  writeback_enable;
        logic [1:0]            instr_class;
        logic [2:0]            memory_operation;
        logic [2:0]            branch_condition;
        logic [XLEN-1:0]       next_address;
    } result_t;

    function automatic logic [REG_ADDR_W-1:0] get_rs1(input logic [XLEN-1:0] instr);
        return instr[19:15];
    endfunction

    function automatic logic [REG_ADDR_W-1:0] get_rs2(input logic [XLEN-1:0] instr);
        return instr[24:20];
    endfunction

endpackage

// ----- hw/rtl/rv32i_instruction_decoder.sv -----
// Top level of the RV32I instruction decoder: input stage, register file and result register.
// The decoder takes one item per clock and keeps that rate as long as results are taken.
// A decode item's instruction and fetch PC are registered at its transfer. At the transfer
// edge, the register file's registered read ports also capture both source registers. The
// word is then decoded, and the result register loads it once that register is empty or its
// result is taken. A register write item takes effect at its own transfer, gives no result,
// and is seen by every later decode. The register file reads as all zeros after reset,
// and x0 always reads zero.
module rv32i_instruction_decoder
    import rvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    logic [XLEN-1:0] s1_instr_reg;
    logic [XLEN-1:0] s1_pc_reg;
    logic            result_valid_reg;
    logic            result_valid_next;
    result_t         result_reg;
    result_t         decoded;
    logic            s1_go;
    logic            item_fire;
    logic            decode_fire;
    logic            write_fire;
    logic [XLEN-1:0] rs1_value;
    logic [XLEN-1:0] rs2_value;

    assign s1_go       = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready  = !s1_valid_reg || s1_go;
    assign item_fire   = item_valid && item_ready;
    assign decode_fire = item_fire && (item.cmd == CMD_DECODE);
    assign write_fire  = item_fire && (item.cmd == CMD_WRITE);

    rvd_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (write_fire),
        .wr_addr   (item.write_index),
        .wr_data   (item.write_value),
        .rd_en     (decode_fire),
        .rd_addr_a (get_rs1(item.instruction)),
        .rd_addr_b (get_rs2(item.instruction)),
        .rd_data_a (rs1_value),
        .rd_data_b (rs2_value)
    );

    rvd_decode u_decode (
        .instruction (s1_instr_reg),
        .fetch_pc    (s1_pc_reg),
        .rs1_value   (rs1_value),
        .rs2_value   (rs2_value),
        .result      (decoded)
    );

    always_comb
    begin
        if (item_fire)
        begin
            s1_valid_next = decode_fire;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_go)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decode_fire)
        begin
            s1_instr_reg <= item.instruction;
            s1_pc_reg    <= item.fetch_pc;
        end
        if (s1_go)
        begin
            result_reg <= decoded;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    a_ready_only_on_full_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !item_ready |-> (s1_valid_reg && result_valid_reg && !result_ready)
    ) else $error("input stalled while the pipeline could move");

    a_advance_fills_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_go |=> result_valid_reg
    ) else $error("decoded item did not reach the result register");

    a_write_leaves_stage_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        write_fire |=> !s1_valid_reg
    ) else $error("register write transfer entered the decode stage");
`endif

endmodule

// ----- hw/rtl/rvd_regfile.sv -----
// Register file with per-entry valid bits, one write port and two registered read ports.
module rvd_regfile
    import rvd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [REG_ADDR_W-1:0] wr_addr,
    input  logic [XLEN-1:0]       wr_data,
    input  logic                  rd_en,
    input  logic [REG_ADDR_W-1:0] rd_addr_a,
    input  logic [REG_ADDR_W-1:0] rd_addr_b,
    output logic [XLEN-1:0]       rd_data_a,
    output logic [XLEN-1:0]       rd_data_b
);

    logic [XLEN-1:0]      mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [XLEN-1:0]      rd_data_a_reg;
    logic [XLEN-1:0]      rd_data_b_reg;
    logic                 wr_live;

    // Register x0 is hardwired to zero, so writes to it are dropped.
    assign wr_live = wr_en && (wr_addr != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_live)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_live)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : '0;
            rd_data_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : '0;
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ----- hw/rtl/rvd_decode.sv -----
// Combinational decode of one instruction word into the result fields.
module rvd_decode
    import rvd_pkg::*;
(
    input  logic [XLEN-1:0] instruction,
    input  logic [XLEN-1:0] fetch_pc,
    input  logic [XLEN-1:0] rs1_value,
    input  logic [XLEN-1:0] rs2_value,
    output result_t         result
);

    logic [6:0]            opcode;
    logic [REG_ADDR_W-1:0] rd;
    logic [2:0]            funct3;
    logic [6:0]            funct7;
    logic [XLEN-1:0]       imm_i;
    logic [XLEN-1:0]       imm_s;
    logic [XLEN-1:0]       imm_b;
    logic [XLEN-1:0]       imm_u;
    logic [XLEN-1:0]       imm_j;
    logic [XLEN-1:0]       pc_plus4;
    logic [XLEN-1:0]       jal_target;
    logic [XLEN-1:0]       jalr_sum;
    logic [XLEN-1:0]       branch_target;
    logic [3:0]            alu_f3;

    assign opcode = instruction[6:0];
    assign rd     = instruction[11:7];
    assign funct3 = instruction[14:12];
    assign funct7 = instruction[31:25];

    assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};
    assign imm_u = {instruction[31:12], 12'b0};
    assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};

    assign pc_plus4      = fetch_pc + XLEN'(4);
    assign jal_target    = fetch_pc + imm_j;
    assign jalr_sum      = rs1_value + imm_i;
    assign branch_target = fetch_pc + imm_b;

    always_comb
    begin
        case (funct3)
            3'd0:    alu_f3 = ALU_ADD;
            3'd1:    alu_f3 = ALU_SLL;
            3'd2:    alu_f3 = ALU_SLT;
            3'd3:    alu_f3 = ALU_SLTU;
            3'd4:    alu_f3 = ALU_XOR;
            3'd5:    alu_f3 = ALU_SRL;
            3'd6:    alu_f3 = ALU_OR;
            default: alu_f3 = ALU_AND;
        endcase
    end

    always_comb
    begin
        result               = '0;
        result.alu_operation = ALU_INVALID;
        result.next_address  = pc_plus4;
        case (opcode)
            OPC_SYSTEM:
            begin
                result.alu_operation = ALU_ECALL;
            end
            OPC_LUI, OPC_AUIPC:
            begin
                result.alu_operation    = ALU_ADD;
                result.operand_a        = (opcode == OPC_AUIPC) ? fetch_pc : '0;
                result.operand_b        = imm_u;
                result.operand_b_is_imm = 1'b1;
                result.dest_reg         = rd;
                result.writeback_source = WB_ALU;
                result.writeback_enable = 1'b1;
            end
            OPC_JAL, OPC_JALR:
            begin
                result.alu_operation    = ALU_ADD;
                result.instr_class      = CLASS_JUMP;
                result.next_address     = (opcode == OPC_JAL) ? jal_target
                                                              : {jalr_sum[XLEN-1:1], 1'b0};
                result.dest_reg         = rd;
                result.writeback_source = WB_PC4;
                result.writeback_enable = 1'b1;
            end
            OPC_BRANCH:
            begin
                result.alu_operation = ALU_ADD;
                result.instr_class   = CLASS_BRANCH;
                result.operand_a     = rs1_value;
                result.operand_b     = rs2_value;
                result.next_address  = branch_target;
                case (funct3)
                    3'd0:    result.branch_condition = BR_EQ;
                    3'd1:    result.branch_condition = BR_NE;
                    3'd4:    result.branch_condition = BR_LT;
                    3'd5:    result.branch_condition = BR_GE;
                    3'd6:    result.branch_condition = BR_LTU;
                    3'd7:    result.branch_condition = BR_GEU;
                    default: result.branch_condition = BR_INVALID;
                endcase
            end
            OPC_LOAD:
            begin
                result.alu_operation    = ALU_ADD;
                result.instr_class      = CLASS_MEMORY;
                result.operand_a        = rs1_value;
                result.operand_b        = imm_i;
                result.operand_b_is_imm = 1'b1;
                result.dest_reg         = rd;
                result.writeback_source = WB_LOAD;
                result.writeback_enable = 1'b1;
                case (funct3)
                    3'd0:    result.memory_operation = MEM_LB;
                    3'd1:    result.memory_operation = MEM_LH;
                    3'd4:    result.memory_operation = MEM_LBU;
                    3'd5:    result.memory_operation = MEM_LHU;
                    default: result.memory_operation = MEM_LW;
                endcase
            end
            OPC_STORE:
            begin
                result.alu_operation    = ALU_ADD;
                result.instr_class      = CLASS_MEMORY;
                result.operand_a        = rs1_value;
                result.operand_b        = imm_s;
                result.operand_b_is_imm = 1'b1;
                result.store_data       = rs2_value;
                case (funct3)
                    3'd0:    result.memory_operation = MEM_SB;
                    3'd1:    result.memory_operation = MEM_SH;
                    default: result.memory_operation = MEM_SW;
                endcase
            end
            OPC_OP_IMM:
            begin
                result.alu_operation    = (funct3 == 3'd5 && funct7 != 7'd0) ? ALU_SRA : alu_f3;
                result.operand_a        = rs1_value;
                result.operand_b        = imm_i;
                result.operand_b_is_imm = 1'b1;
                result.dest_reg         = rd;
                result.writeback_source = WB_ALU;
                result.writeback_enable = 1'b1;
            end
            OPC_OP:
            begin
                if (funct7 == 7'h00)
                begin
                    result.alu_operation = alu_f3;
                end
                else if (funct7 == 7'h20 && funct3 == 3'd0)
                begin
                    result.alu_operation = ALU_SUB;
                end
                else if (funct7 == 7'h20 && funct3 == 3'd5)
                begin
                    result.alu_operation = ALU_SRA;
                end
                else
                begin
                    result.alu_operation = ALU_INVALID;
                end
                result.operand_a        = rs1_value;
                result.operand_b        = rs2_value;
                result.dest_reg         = rd;
                result.writeback_source = WB_ALU;
                result.writeback_enable = 1'b1;
            end
            default:
            begin
                result.alu_operation = ALU_INVALID;
            end
        endcase
    end

endmodule
